// ===== design/sha1_pkg.sv =====
// sha1_pkg: shared types, constants and round functions for the sha1 stream hasher
// no dependencies
package sha1_pkg;

  localparam int BlockBytes = 64;
  localparam int DigestWords = 5;
  localparam int QueueDepth = 4;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  // classified transaction from the front part
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } item_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = H0;
      3'd1: v = H1;
      3'd2: v = H2;
      3'd3: v = H3;
      default: v = H4;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] v;
    priority if (r < 7'd20) v = (b & c) | (~b & d);
    else if (r < 7'd40) v = b ^ c ^ d;
    else if (r < 7'd60) v = (b & c) | (b & d) | (c & d);
    else v = b ^ c ^ d;
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] v;
    priority if (r < 7'd20) v = K0;
    else if (r < 7'd40) v = K1;
    else if (r < 7'd60) v = K2;
    else v = K3;
    return v;
  endfunction

endpackage

// ===== design/sha1_front.sv =====
// sha1_front: input skid queue that accepts and classifies transactions
// depends on sha1_pkg
module sha1_front #(
  parameter int Depth = sha1_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha1_pkg::item_t   in_item,
  output logic              q_valid,
  input  logic              q_take,
  output sha1_pkg::item_t   q_item
);
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha1_pkg::item_t mem_r [Depth];
  logic [Aw-1:0] wp_r, rp_r;
  logic [Aw:0]   cnt_r;
  logic push, pop, keep;

  // idle items carry no work and are dropped here
  assign keep     = in_item.has | in_item.last;
  assign in_stall = (cnt_r == (Aw+1)'(Depth));
  assign push     = in_valid & ~in_stall & keep;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid & q_take;
  assign q_item   = mem_r[rp_r];

  function automatic logic [Aw-1:0] inc(input logic [Aw-1:0] p);
    return (p == Aw'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc(wp_r);
      if (pop) rp_r <= inc(rp_r);
      cnt_r <= cnt_r + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule

// ===== design/sha1_back.sv =====
// sha1_back: block buffer, padding sequencer, 80-round compression and digest output
// depends on sha1_pkg
module sha1_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_take,
  input  sha1_pkg::item_t   q_item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RND = 3'd1, S_FIN = 3'd2, S_PAD = 3'd3,
                         S_OUT = 3'd4;

  logic [2:0]  st_r;
  logic [63:0] cnt_r;
  logic [63:0] len_r;
  logic        fin_r;     // message end pending
  logic        pad0_r;    // 0x80 already placed
  logic        lenph_r;   // length bytes under way
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];  // block buffer, big-endian words, reused as schedule window
  logic [6:0]  rnd_r;
  logic [2:0]  oi_r;

  logic [5:0]  pos;
  logic        wr;
  logic [7:0]  wbyte;
  logic [31:0] wcur, wx, wnew, t;
  logic [7:0]  padb;

  assign pos = cnt_r[8:3];
  assign q_take = (st_r == S_IDLE) && q_valid;

  // padding byte selection
  always_comb begin
    if (!pad0_r) padb = sha1_pkg::PadByte;
    else if (!lenph_r && pos != 6'd56) padb = 8'h00;
    else padb = len_r[{~pos[2:0], 3'b000} +: 8];
  end

  always_comb begin
    wr = 1'b0;
    wbyte = q_item.data;
    if (q_take && q_item.has) wr = 1'b1;
    if (st_r == S_PAD) begin
      wr = 1'b1;
      wbyte = padb;
    end
  end

  // window holds w[r-16] at 0 up to w[r-1] at 15
  assign wx   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wnew = {wx[30:0], wx[31]};
  assign wcur = (rnd_r < 7'd16) ? w_r[0] : wnew;
  assign t = {a_r[26:0], a_r[31:27]} + sha1_pkg::round_f(rnd_r, b_r, c_r, d_r) + e_r
             + sha1_pkg::round_k(rnd_r) + wcur;

  assign out_valid = (st_r == S_OUT);
  assign out_digest_word = h_r[oi_r];
  assign out_word_index = oi_r;
  assign out_last_word = (oi_r == 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      fin_r <= 1'b0;
      pad0_r <= 1'b0;
      lenph_r <= 1'b0;
      rnd_r <= '0;
      oi_r <= '0;
      for (int i = 0; i < 5; i++) h_r[i] <= sha1_pkg::init_word(3'(i));
    end else begin
      if (wr) w_r[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= wbyte;
      unique case (st_r)
        S_IDLE: if (q_take) begin
          if (q_item.has) cnt_r <= cnt_r + 64'd8;
          if (q_item.last) begin
            fin_r <= 1'b1;
            len_r <= cnt_r + (q_item.has ? 64'd8 : 64'd0);
          end
          if (q_item.has && pos == 6'd63) begin
            st_r <= S_RND;
            rnd_r <= '0;
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
          end else if (q_item.last) st_r <= S_PAD;
        end
        S_PAD: begin
          cnt_r <= cnt_r + 64'd8;
          pad0_r <= 1'b1;
          if (pad0_r && pos == 6'd56) lenph_r <= 1'b1;
          if (pos == 6'd63) begin
            st_r <= S_RND;
            rnd_r <= '0;
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
          end
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wcur;
          e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= t;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) st_r <= S_FIN;
        end
        S_FIN: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
          // done once the length bytes went into the block just closed
          if (!fin_r) st_r <= S_IDLE;
          else if (lenph_r) begin
            st_r <= S_OUT;
            oi_r <= '0;
          end else st_r <= S_PAD;
        end
        S_OUT: if (!out_stall) begin
          if (oi_r == 3'd4) begin
            st_r <= S_IDLE;
            oi_r <= '0;
            fin_r <= 1'b0;
            pad0_r <= 1'b0;
            lenph_r <= 1'b0;
            cnt_r <= '0;
            for (int i = 0; i < 5; i++) h_r[i] <= sha1_pkg::init_word(3'(i));
          end else oi_r <= oi_r + 3'd1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/sha1_stream_hasher.sv =====
// sha1_stream_hasher: top level of the byte-stream sha-1 hasher
// depends on sha1_pkg, sha1_front, sha1_back
//
// usage:
//  input channel in_valid/in_stall carries one byte transaction: in_data_byte,
//  in_has_byte (byte is part of the message) and in_last_byte (end of message)
//  output channel out_valid/out_stall carries the five digest words, word 0
//  first, with out_word_index on each word and out_last_word on the fifth
//  a front queue of four entries takes transactions while the back part works
//  the back part writes one byte a cycle into a 64-byte buffer while idle and
//  the queue holds entries; a full block then runs through 80 rounds in the
//  one-round-per-cycle compression unit and is added into the chaining value;
//  no bytes are taken meanwhile
//  a last transaction adds padding bytes and up to two compressions before the
//  first digest word; words then leave one a cycle while out_stall is low; a
//  stalled receiver holds the current word and the queue then fills and raises
//  in_stall
//  reset clears counters and loads the initial chaining value; the buffer is
//  not cleared
module sha1_stream_hasher #(
  parameter int QueueDepth = sha1_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  sha1_pkg::item_t in_item, q_item;
  logic q_valid, q_take;

  assign in_item = '{data: in_data_byte, has: in_has_byte, last: in_last_byte};

  sha1_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .q_valid, .q_take, .q_item
  );

  sha1_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_item,
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );
endmodule
